>>> design/mssu_pkg.sv
`timescale 1ns / 1ps

package mssu_pkg;

   // Lattice geometry. SIZE must be a power of two so that index wraparound
   // is a plain truncation.
   localparam int SIZE      = 64;
   localparam int NEIGHBORS = 4;
   localparam int IDX_W     = $clog2(SIZE);
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int CELLS     = SIZE * SIZE;
   localparam int NB_W      = $clog2(NEIGHBORS);

   // Field widths.
   localparam int ROW_IN_W  = 6;
   localparam int OFF_W     = 3;
   localparam int CODE_W    = 2;
   localparam int BUDGET_W  = 16;
   localparam int MAG_W     = 15;
   localparam int CSR_IDX_W = 3;
   localparam int SPIN_W    = 3;
   localparam int SUM_W     = 5;
   localparam int DIFF_W    = 4;
   localparam int DE_W      = 9;
   localparam int CMP_W     = BUDGET_W + 2;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Magnetization after reset: every spin at +3.
   localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(3 * CELLS);

   // Spin value of each 2-bit code.
   localparam logic signed [SPIN_W-1:0] SPIN_VALUE [4] = '{3'sd3, 3'sd1, -3'sd1, -3'sd3};

   // Reset values of the neighbour offsets, in register order.
   localparam logic [OFF_W-1:0] OFF_RESET [2*NEIGHBORS] =
      '{3'd1, 3'd0, 3'd7, 3'd0, 3'd0, 3'd1, 3'd0, 3'd7};

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NB0_ROW = 3'd0,
      CSR_NB0_COL = 3'd1,
      CSR_NB1_ROW = 3'd2,
      CSR_NB1_COL = 3'd3,
      CSR_NB2_ROW = 3'd4,
      CSR_NB2_COL = 3'd5,
      CSR_NB3_ROW = 3'd6,
      CSR_NB3_COL = 3'd7
   } csr_index_type;

   // One classified update travelling from front to back.
   typedef struct packed {
      logic [ADDR_W-1:0]                  site_addr;
      logic [NEIGHBORS-1:0][ADDR_W-1:0]   nb_addr;
      logic [CODE_W-1:0]                  pcode;
      logic [BUDGET_W-1:0]                budget;
   } item_type;

   // Add a signed 3-bit offset to an index, modulo SIZE.
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                 input logic [OFF_W-1:0] off);
      logic [IDX_W+OFF_W-1:0] ext;
      ext = {{IDX_W{off[OFF_W-1]}}, off};
      return idx + ext[IDX_W-1:0];
   endfunction

   // Spin value of a code.
   function automatic logic signed [SPIN_W-1:0] spin_val(input logic [CODE_W-1:0] code);
      return SPIN_VALUE[code];
   endfunction

endpackage

>>> design/mssu_ram.sv
`timescale 1ns / 1ps

module mssu_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port: write and registered read at one address per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/mssu_front.sv
`timescale 1ns / 1ps

module mssu_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [mssu_pkg::ROW_IN_W-1:0]    req_site_row,
   input  logic [mssu_pkg::ROW_IN_W-1:0]    req_site_col,
   input  logic [mssu_pkg::CODE_W-1:0]      req_proposed_code,
   input  logic [mssu_pkg::BUDGET_W-1:0]    req_energy_budget,
   input  logic                             csr_write_en,
   input  logic [mssu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mssu_pkg::OFF_W-1:0]       csr_wdata,
   input  logic                             queue_full,
   input  logic                             clearing,
   output logic                             push,
   output mssu_pkg::item_type               push_item
);

   logic [mssu_pkg::OFF_W-1:0] offs_ff [2*mssu_pkg::NEIGHBORS];
   logic [mssu_pkg::OFF_W-1:0] offs_in [2*mssu_pkg::NEIGHBORS];
   logic [mssu_pkg::IDX_W-1:0] row;
   logic [mssu_pkg::IDX_W-1:0] col;

   // Offset register write decode.
   always_comb begin
      for (int k = 0; k < 2*mssu_pkg::NEIGHBORS; k++) begin
         offs_in[k] = offs_ff[k];
      end
      if (csr_write_en) begin
         case (mssu_pkg::csr_index_type'(csr_index))
            mssu_pkg::CSR_NB0_ROW: offs_in[0] = csr_wdata;
            mssu_pkg::CSR_NB0_COL: offs_in[1] = csr_wdata;
            mssu_pkg::CSR_NB1_ROW: offs_in[2] = csr_wdata;
            mssu_pkg::CSR_NB1_COL: offs_in[3] = csr_wdata;
            mssu_pkg::CSR_NB2_ROW: offs_in[4] = csr_wdata;
            mssu_pkg::CSR_NB2_COL: offs_in[5] = csr_wdata;
            mssu_pkg::CSR_NB3_ROW: offs_in[6] = csr_wdata;
            mssu_pkg::CSR_NB3_COL: offs_in[7] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2*mssu_pkg::NEIGHBORS; k++) begin
            offs_ff[k] <= mssu_pkg::OFF_RESET[k];
         end
      end else begin
         for (int k = 0; k < 2*mssu_pkg::NEIGHBORS; k++) begin
            offs_ff[k] <= offs_in[k];
         end
      end
   end

   // A word is taken whenever the queue has room and the store is ready.
   assign busy = queue_full | clearing;
   assign push = start & ~busy;

   // Reduce the site modulo the lattice size and form the five addresses.
   assign row = mssu_pkg::IDX_W'(req_site_row);
   assign col = mssu_pkg::IDX_W'(req_site_col);

   always_comb begin
      push_item.site_addr = {row, col};
      for (int n = 0; n < mssu_pkg::NEIGHBORS; n++) begin
         push_item.nb_addr[n] = {mssu_pkg::wrap_add(row, offs_ff[2*n]),
                                 mssu_pkg::wrap_add(col, offs_ff[2*n+1])};
      end
      push_item.pcode  = req_proposed_code;
      push_item.budget = req_energy_budget;
   end

endmodule

>>> design/mssu_queue.sv
`timescale 1ns / 1ps

module mssu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mssu_pkg::item_type  push_item,
   input  logic                pop,
   output mssu_pkg::item_type  head,
   output logic                empty,
   output logic                full
);

   mssu_pkg::item_type               slot_ff [mssu_pkg::QUEUE_DEPTH];
   logic [mssu_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [mssu_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [mssu_pkg::QPTR_W:0]        count_ff;
   logic [mssu_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [mssu_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [mssu_pkg::QPTR_W:0]        count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (mssu_pkg::QPTR_W+1)'(mssu_pkg::QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/mssu_back.sv
`timescale 1ns / 1ps

module mssu_back (
   input  logic                                clock,
   input  logic                                reset,
   input  mssu_pkg::item_type                  head,
   input  logic                                empty,
   output logic                                pop,
   output logic                                clearing,
   output logic                                rsp_strobe,
   output logic                                rsp_accepted,
   output logic [mssu_pkg::CODE_W-1:0]         rsp_spin_code_after,
   output logic signed [mssu_pkg::MAG_W-1:0]   rsp_magnet_sum
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DECIDE
   } state_type;

   state_type                            state_ff, state_in;
   logic [mssu_pkg::ADDR_W-1:0]          clr_ff, clr_in;
   logic [mssu_pkg::NB_W-1:0]            nb_ff, nb_in;
   mssu_pkg::item_type                   cur_ff, cur_in;
   logic [mssu_pkg::CODE_W-1:0]          ocode_ff, ocode_in;
   logic signed [mssu_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [mssu_pkg::MAG_W-1:0]           magnet_ff, magnet_in;
   logic                                 strobe_ff, strobe_in;
   logic                                 acc_ff, acc_in;
   logic [mssu_pkg::CODE_W-1:0]          code_ff, code_in;

   logic                                 ram_we;
   logic [mssu_pkg::ADDR_W-1:0]          ram_addr;
   logic [mssu_pkg::CODE_W-1:0]          ram_wdata;
   logic [mssu_pkg::CODE_W-1:0]          ram_rdata;

   logic signed [mssu_pkg::SPIN_W-1:0]   rd_val;
   logic signed [mssu_pkg::SUM_W-1:0]    rd_val_ext;
   logic signed [mssu_pkg::SUM_W-1:0]    nsum;
   logic signed [mssu_pkg::DIFF_W-1:0]   diff;
   logic signed [mssu_pkg::DE_W-1:0]     de;
   logic signed [mssu_pkg::CMP_W-1:0]    budget_s;
   logic signed [mssu_pkg::CMP_W-1:0]    de_scaled;
   logic                                 acc;

   mssu_ram #(
      .WIDTH (mssu_pkg::CODE_W),
      .DEPTH (mssu_pkg::CELLS)
   ) u_spin_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Energy change and Metropolis test, valid when the last neighbour arrives.
   assign rd_val     = mssu_pkg::spin_val(ram_rdata);
   assign rd_val_ext = {{(mssu_pkg::SUM_W-mssu_pkg::SPIN_W){rd_val[mssu_pkg::SPIN_W-1]}},
                        rd_val};
   assign nsum       = sum_ff + rd_val_ext;
   assign diff       = mssu_pkg::DIFF_W'(mssu_pkg::spin_val(cur_ff.pcode))
                     - mssu_pkg::DIFF_W'(mssu_pkg::spin_val(ocode_ff));
   assign de         = -(mssu_pkg::DE_W'(diff) * mssu_pkg::DE_W'(nsum));
   assign budget_s   = {2'b00, cur_ff.budget};
   assign de_scaled  = {de[mssu_pkg::DE_W-1], de, 8'b0};
   assign acc        = de[mssu_pkg::DE_W-1] | (budget_s > de_scaled);

   // Sequencer: clearing pass, then one read of the site, four neighbour
   // reads and a decision step per word, writing back an accepted spin.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      nb_in     = nb_ff;
      cur_in    = cur_ff;
      ocode_in  = ocode_ff;
      sum_in    = sum_ff;
      magnet_in = magnet_ff;
      strobe_in = 1'b0;
      acc_in    = acc_ff;
      code_in   = code_ff;
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = cur_ff.site_addr;
      ram_wdata = cur_ff.pcode;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == mssu_pkg::ADDR_W'(mssu_pkg::CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               cur_in   = head;
               ram_addr = head.site_addr;
               nb_in    = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ram_addr = cur_ff.nb_addr[nb_ff];
            if (nb_ff == '0) begin
               ocode_in = ram_rdata;
               sum_in   = '0;
            end else begin
               sum_in = nsum;
            end
            nb_in = nb_ff + 1'b1;
            if (nb_ff == mssu_pkg::NB_W'(mssu_pkg::NEIGHBORS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            ram_we    = acc;
            strobe_in = 1'b1;
            acc_in    = acc;
            code_in   = acc ? cur_ff.pcode : ocode_ff;
            if (acc) begin
               magnet_in = magnet_ff
                         + {{(mssu_pkg::MAG_W-mssu_pkg::DIFF_W){diff[mssu_pkg::DIFF_W-1]}},
                            diff};
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         nb_ff     <= '0;
         magnet_ff <= mssu_pkg::MAG_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         nb_ff     <= nb_in;
         magnet_ff <= magnet_in;
         strobe_ff <= strobe_in;
      end
      cur_ff   <= cur_in;
      ocode_ff <= ocode_in;
      sum_ff   <= sum_in;
      acc_ff   <= acc_in;
      code_ff  <= code_in;
   end

   assign clearing            = (state_ff == ST_CLEAR);
   assign rsp_strobe          = strobe_ff;
   assign rsp_accepted        = acc_ff;
   assign rsp_spin_code_after = code_ff;
   assign rsp_magnet_sum      = magnet_ff;

endmodule

>>> design/metropolis_spin_site_update.sv
`timescale 1ns / 1ps

// Metropolis update of one site of a 64 x 64 toroidal lattice of four-level
// spins. A word is issued on req_* with start; it is taken at a clock edge
// where start is high and busy is low. Each word names a site, a proposed
// spin code and an energy budget, and produces exactly one result word on
// rsp_*, marked by rsp_strobe for a single cycle. The receiver cannot stall.
// The front takes words into a two-entry queue; the back reads the site and
// its four neighbours from a single-port spin store, one read per cycle, and
// then decides and, on acceptance, writes the new spin back. The back handles
// one word at a time, while the queue goes on taking words while it has room,
// so a new word can be taken before the last result is out.
// Neighbour offsets are written on csr_* while the block is idle.
// After reset, busy stays high while the spin store is swept to +3; offsets
// return to the four nearest neighbours and the magnetization to 12288.
module metropolis_spin_site_update (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mssu_pkg::ROW_IN_W-1:0]       req_site_row,
   input  logic [mssu_pkg::ROW_IN_W-1:0]       req_site_col,
   input  logic [mssu_pkg::CODE_W-1:0]         req_proposed_code,
   input  logic [mssu_pkg::BUDGET_W-1:0]       req_energy_budget,
   output logic                                rsp_strobe,
   output logic                                rsp_accepted,
   output logic [mssu_pkg::CODE_W-1:0]         rsp_spin_code_after,
   output logic signed [mssu_pkg::MAG_W-1:0]   rsp_magnet_sum,
   input  logic                                csr_write_en,
   input  logic [mssu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mssu_pkg::OFF_W-1:0]          csr_wdata
);

   logic               q_push;
   logic               q_pop;
   logic               q_empty;
   logic               q_full;
   logic               clearing;
   mssu_pkg::item_type push_item;
   mssu_pkg::item_type q_head;

   // Front: takes words, holds the offsets and forms the addresses.
   mssu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_site_row      (req_site_row),
      .req_site_col      (req_site_col),
      .req_proposed_code (req_proposed_code),
      .req_energy_budget (req_energy_budget),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .queue_full        (q_full),
      .clearing          (clearing),
      .push              (q_push),
      .push_item         (push_item)
   );

   // Queue between front and back.
   mssu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Back: store access, Metropolis test and magnetization.
   mssu_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (q_head),
      .empty               (q_empty),
      .pop                 (q_pop),
      .clearing            (clearing),
      .rsp_strobe          (rsp_strobe),
      .rsp_accepted        (rsp_accepted),
      .rsp_spin_code_after (rsp_spin_code_after),
      .rsp_magnet_sum      (rsp_magnet_sum)
   );

   // A result strobe is never followed at once by another.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobes in consecutive cycles");

   // The magnetization only moves together with a result.
   assert property (@(posedge clock) disable iff (reset)
                    !rsp_strobe |-> $stable(rsp_magnet_sum))
      else $error("magnetization changed without a result");

   // The back never takes from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("queue popped while empty");

   // No result leaves while the store is being swept.
   assert property (@(posedge clock) disable iff (reset) clearing |-> !rsp_strobe)
      else $error("result during the clearing pass");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int LATTICE     = 64;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 250;
   localparam int SETTLE      = 12;
   localparam int CYCLE_LIMIT = 250000;

   // Neighbour offsets after reset: down, up, right, left.
   localparam logic [2:0] OFFSETS_AT_RESET [8] =
      '{3'd1, 3'd0, 3'd7, 3'd0, 3'd0, 3'd1, 3'd0, 3'd7};

   typedef struct packed {
      logic [5:0]  row;
      logic [5:0]  col;
      logic [1:0]  code;
      logic [15:0] budget;
   } flip_request_type;

   typedef struct packed {
      logic              accepted;
      logic [1:0]        code_after;
      logic signed [14:0] magnet;
   } flip_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [5:0]  req_site_row = '0;
   logic [5:0]  req_site_col = '0;
   logic [1:0]  req_proposed_code = '0;
   logic [15:0] req_energy_budget = '0;
   logic        rsp_strobe;
   logic        rsp_accepted;
   logic [1:0]  rsp_spin_code_after;
   logic signed [14:0] rsp_magnet_sum;
   logic        csr_write_en = 1'b0;
   mssu_pkg::csr_index_type csr_index = mssu_pkg::CSR_NB0_ROW;
   logic [2:0]  csr_wdata = '0;

   // Lattice model: spin codes, running magnetization and neighbour offsets.
   logic [1:0] lattice_codes [LATTICE*LATTICE];
   int         lattice_magnet;
   logic [2:0] neighbour_offsets [8];

   flip_request_type pending_requests [$];
   flip_outcome_type expected_outcomes [$];

   int idle_pct = 6;
   bit drain_hold = 1'b0;
   int issued_count = 0;
   int checked_count = 0;
   int accepted_count = 0;
   int error_count = 0;
   int cycle_count = 0;

   metropolis_spin_site_update dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_site_row        (req_site_row),
      .req_site_col        (req_site_col),
      .req_proposed_code   (req_proposed_code),
      .req_energy_budget   (req_energy_budget),
      .rsp_strobe          (rsp_strobe),
      .rsp_accepted        (rsp_accepted),
      .rsp_spin_code_after (rsp_spin_code_after),
      .rsp_magnet_sum      (rsp_magnet_sum),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int spin_of(input logic [1:0] code);
      case (code)
         2'd0:    return 3;
         2'd1:    return 1;
         2'd2:    return -1;
         default: return -3;
      endcase
   endfunction

   function automatic int offset_of(input logic [2:0] v);
      return v[2] ? int'(v) - 8 : int'(v);
   endfunction

   // Metropolis decision for one word; updates the lattice model on acceptance.
   function automatic flip_outcome_type metropolis_predict(input flip_request_type q);
      int row;
      int col;
      int r;
      int c;
      int nsum;
      int diff;
      int de;
      logic [1:0] old_code;
      flip_outcome_type res;
      row = int'(q.row) % LATTICE;
      col = int'(q.col) % LATTICE;
      old_code = lattice_codes[row*LATTICE + col];
      nsum = 0;
      for (int n = 0; n < 4; n++) begin
         r = (row + offset_of(neighbour_offsets[2*n]) + LATTICE) % LATTICE;
         c = (col + offset_of(neighbour_offsets[2*n+1]) + LATTICE) % LATTICE;
         nsum += spin_of(lattice_codes[r*LATTICE + c]);
      end
      diff = spin_of(q.code) - spin_of(old_code);
      de = -diff * nsum;
      res.accepted = (de < 0) || (int'(q.budget) > 256 * de);
      if (res.accepted) begin
         lattice_codes[row*LATTICE + col] = q.code;
         lattice_magnet += diff;
      end
      res.code_after = lattice_codes[row*LATTICE + col];
      res.magnet = lattice_magnet[14:0];
      return res;
   endfunction

   // Driver: one word at a time from the pending queue, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_outcomes.push_back(metropolis_predict(
               {req_site_row, req_site_col, req_proposed_code, req_energy_budget}));
         end
         if (drain_hold && expected_outcomes.size() == 0 && !start) begin
            drain_hold = 1'b0;
         end
         if ((start && !busy) || !start) begin
            if (pending_requests.size() > 0 && !drain_hold &&
                $urandom_range(0, 99) >= idle_pct) begin
               {req_site_row, req_site_col, req_proposed_code, req_energy_budget}
                  <= pending_requests.pop_front();
               start <= 1'b1;
               issued_count++;
               // Now and then hold off until the block has emptied completely.
               if (issued_count == 40 || $urandom_range(0, 199) == 0) begin
                  drain_hold = 1'b1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed word is checked against the oldest prediction.
   always @(posedge clock) begin
      flip_outcome_type exp_out;
      if (!reset && rsp_strobe) begin
         if (expected_outcomes.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            exp_out = expected_outcomes.pop_front();
            checked_count++;
            if (rsp_accepted) accepted_count++;
            if (rsp_accepted !== exp_out.accepted) begin
               $error("accepted: expected %0d, got %0d", exp_out.accepted, rsp_accepted);
               error_count++;
            end
            if (rsp_spin_code_after !== exp_out.code_after) begin
               $error("spin_code_after: expected %0d, got %0d",
                      exp_out.code_after, rsp_spin_code_after);
               error_count++;
            end
            if (rsp_magnet_sum !== exp_out.magnet) begin
               $error("magnet_sum: expected %0d, got %0d", exp_out.magnet, rsp_magnet_sum);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic queue_flip(input int row, input int col, input int code, input int budget);
      pending_requests.push_back({6'(row), 6'(col), 2'(code), 16'(budget)});
   endtask

   // Wait until no word is queued, in flight or awaiting its result.
   task automatic wait_idle();
      while (pending_requests.size() != 0 || expected_outcomes.size() != 0 || start) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // Rewrite all eight offset registers; the pattern depends on the phase.
   task automatic write_offsets(input int phase);
      mssu_pkg::csr_index_type idx;
      logic [2:0] v;
      idx = mssu_pkg::CSR_NB0_ROW;
      for (int k = 0; k < 8; k++) begin
         case (phase)
            0:       v = 3'b100;
            1:       v = 3'b011;
            5:       v = (k % 2 == 0) ? 3'b101 : 3'b000;
            6:       v = OFFSETS_AT_RESET[k];
            default: v = 3'($urandom_range(0, 7));
         endcase
         @(posedge clock);
         csr_write_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= v;
         neighbour_offsets[idx] = v;
         idx = idx.next();
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Random word, often clustered so that neighbouring spins differ.
   function automatic flip_request_type random_flip(input int base_row, input int base_col);
      flip_request_type q;
      if ($urandom_range(0, 9) < 6) begin
         q.row = 6'((base_row + $urandom_range(0, 5)) % LATTICE);
         q.col = 6'((base_col + $urandom_range(0, 5)) % LATTICE);
      end else begin
         q.row = 6'($urandom_range(0, 63));
         q.col = 6'($urandom_range(0, 63));
      end
      q.code = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0:       q.budget = 16'd0;
         1:       q.budget = 16'hFFFF;
         2, 3:    q.budget = 16'(256 * $urandom_range(0, 72) + $urandom_range(0, 1));
         4, 5:    q.budget = 16'($urandom_range(0, 2048));
         6, 7, 8: q.budget = 16'($urandom_range(0, 20000));
         default: q.budget = 16'($urandom_range(0, 65535));
      endcase
      return q;
   endfunction

   initial begin
      int base_row;
      int base_col;
      for (int i = 0; i < LATTICE*LATTICE; i++) lattice_codes[i] = 2'd0;
      lattice_magnet = 3 * LATTICE * LATTICE;
      for (int k = 0; k < 8; k++) neighbour_offsets[k] = OFFSETS_AT_RESET[k];

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words on the nearest-neighbour lattice, starting all +3.
      idle_pct = 6;
      queue_flip(0, 0, 0, 0);          // no energy change, no budget: rejected
      queue_flip(0, 0, 0, 1);          // no energy change, budget 1: accepted
      queue_flip(0, 0, 1, 6144);       // budget exactly 256*dE: rejected
      queue_flip(0, 0, 1, 6145);
      queue_flip(63, 63, 3, 0);
      queue_flip(63, 63, 3, 65535);
      queue_flip(63, 63, 0, 0);        // energy falls: accepted on no budget
      queue_flip(63, 63, 3, 65535);
      queue_flip(0, 63, 2, 65535);     // wraps on both axes
      queue_flip(63, 0, 2, 32768);
      queue_flip(1, 0, 3, 65535);
      queue_flip(0, 1, 2, 12000);
      queue_flip(62, 63, 1, 0);
      queue_flip(32, 17, 3, 65535);
      queue_flip(21, 42, 1, 65535);
      queue_flip(42, 21, 2, 0);
      queue_flip(0, 0, 3, 65535);
      queue_flip(1, 1, 0, 100);
      queue_flip(63, 63, 3, 1);        // proposal equal to current spin
      wait_idle();

      // Random phases, each with its neighbour pattern written anew and one of three idle profiles.
      for (int p = 0; p < PHASES; p++) begin
         idle_pct = (p < 3) ? 6 : (p < 5) ? 55 : 0;
         write_offsets(p);
         base_row = $urandom_range(0, 63);
         base_col = $urandom_range(0, 63);
         repeat (PHASE_ITEMS) pending_requests.push_back(random_flip(base_row, base_col));
         wait_idle();
      end

      $display("tb_top: %0d updates checked, %0d accepted, %0d rejected",
               checked_count, accepted_count, checked_count - accepted_count);
      $display("tb_top: %0d neighbour patterns including -4 and +3 offsets", PHASES + 1);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

>>> metropolis_spin_site_update.f
design/mssu_pkg.sv
design/mssu_ram.sv
design/mssu_front.sv
design/mssu_queue.sv
design/mssu_back.sv
design/metropolis_spin_site_update.sv
tb/tb_top.sv
